>>> hw/rtl/mlk_pkg.sv
package mlk_pkg;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_TICK    = 2'd1,
        OP_RESTART = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    typedef struct packed {
        logic lamp_on;
        logic done_res;
        logic dropped;
    } res_t;

    localparam int          PAT_SLOTS       = 5;
    localparam int          PAT_W           = 2 * PAT_SLOTS;
    localparam int          CODE_SLOTS      = 4;
    localparam logic [15:0] DOT_TICKS_RESET = 16'd10;
    localparam logic [7:0]  CHAR_SPACE      = 8'h20;
    localparam logic [7:0]  CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0]  CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0]  CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0]  CHAR_LOWER_Z    = 8'h7A;
    localparam logic [7:0]  CASE_OFFSET     = 8'h20;
    localparam logic [2:0]  LEN_SPACE       = 3'd4;
    localparam logic [2:0]  LEN_OTHER       = 3'd1;

    // {element count, dash mask}; bit k of the mask marks element k as a dash
    function automatic logic [6:0] letter_code(input logic [4:0] idx);
        logic [6:0] code;
        case (idx)
            5'd0:    code = {3'd2, 4'b0010};
            5'd1:    code = {3'd4, 4'b0001};
            5'd2:    code = {3'd4, 4'b0101};
            5'd3:    code = {3'd3, 4'b0001};
            5'd4:    code = {3'd1, 4'b0000};
            5'd5:    code = {3'd4, 4'b0100};
            5'd6:    code = {3'd3, 4'b0011};
            5'd7:    code = {3'd4, 4'b0000};
            5'd8:    code = {3'd2, 4'b0000};
            5'd9:    code = {3'd4, 4'b1110};
            5'd10:   code = {3'd3, 4'b0101};
            5'd11:   code = {3'd4, 4'b0010};
            5'd12:   code = {3'd2, 4'b0011};
            5'd13:   code = {3'd2, 4'b0001};
            5'd14:   code = {3'd3, 4'b0111};
            5'd15:   code = {3'd4, 4'b0110};
            5'd16:   code = {3'd4, 4'b1011};
            5'd17:   code = {3'd3, 4'b0010};
            5'd18:   code = {3'd3, 4'b0000};
            5'd19:   code = {3'd1, 4'b0001};
            5'd20:   code = {3'd3, 4'b0100};
            5'd21:   code = {3'd4, 4'b1000};
            5'd22:   code = {3'd3, 4'b0110};
            5'd23:   code = {3'd4, 4'b1001};
            5'd24:   code = {3'd4, 4'b1101};
            5'd25:   code = {3'd4, 4'b0011};
            default: code = {3'd0, 4'b0000};
        endcase
        return code;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/mlk_cmd_if.sv
interface mlk_cmd_if
    import mlk_pkg::*;
();
    logic       valid;
    logic       ready;
    op_t        op;
    logic [7:0] char_code;

    modport source (output valid, output op, output char_code, input ready);
    modport sink   (input valid, input op, input char_code, output ready);
endinterface

>>> hw/rtl/mlk_res_if.sv
interface mlk_res_if;
    logic valid;
    logic ready;
    logic lamp_on;
    logic done_res;
    logic dropped;

    modport source (output valid, output lamp_on, output done_res, output dropped, input ready);
    modport sink   (input valid, input lamp_on, input done_res, input dropped, output ready);
endinterface

>>> hw/rtl/mlk_res_fifo.sv
module mlk_res_fifo
    import mlk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  res_t      push_data,
    output logic      full,
    mlk_res_if.source res
);

    res_t       q_reg [2];
    logic       head_reg;
    logic       head_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       tail;
    logic       pop;
    res_t       head_data;

    assign tail      = head_reg ^ count_reg[0];
    assign pop       = res.valid && res.ready;
    assign full      = (count_reg == 2'd2);
    assign head_data = q_reg[head_reg];

    assign res.valid    = (count_reg != 2'd0);
    assign res.lamp_on  = head_data.lamp_on;
    assign res.done_res = head_data.done_res;
    assign res.dropped  = head_data.dropped;

    always_comb
    begin
        head_next  = head_reg ^ pop;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[tail] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> hw/rtl/morse_lamp_keyer_core.sv
// A result is valid in the cycle after its request is accepted, if none waits ahead.
// Throughput: one request per cycle; a two-entry result buffer keeps requests
// flowing while a result waits to be taken, so ready drops only when it is full.
// Reset (rst_n, async): clears playback state, message length and the result
// buffer, and sets dot_ticks to 10. Message buffer contents are left undefined.
module morse_lamp_keyer_core
    import mlk_pkg::*;
#(
    parameter int MESSAGE_DEPTH = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    mlk_cmd_if.sink      cmd,
    mlk_res_if.source    res
);

    localparam int AW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
    localparam int LW = $clog2(MESSAGE_DEPTH + 1);
    localparam logic [LW-1:0] DEPTH_L = LW'(MESSAGE_DEPTH);

    logic [7:0]       mem [MESSAGE_DEPTH];
    logic [7:0]       rd_data_reg;

    logic [15:0]      dot_ticks_reg;
    logic [LW-1:0]    len_reg, len_next;
    logic [LW-1:0]    rp_reg, rp_next;
    logic [PAT_W-1:0] pat_reg, pat_next;
    logic [2:0]       plen_reg, plen_next;
    logic [2:0]       ep_reg, ep_next;
    logic [15:0]      tick_reg, tick_next;
    logic             lamp_reg, lamp_next;
    logic             done_reg, done_next;

    logic             accept;
    logic             fifo_full;
    logic             buf_full;
    logic             drop;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       folded;
    logic [6:0]       code;
    logic [PAT_W-1:0] load_pat;
    logic [2:0]       load_len;
    logic [1:0]       fld;
    res_t             res_data;

    assign cmd.ready = !fifo_full;
    assign accept    = cmd.valid && cmd.ready;
    assign buf_full  = (len_reg >= DEPTH_L);
    assign folded    = fold_case(cmd.char_code);
    assign wr_en     = accept && (cmd.op == OP_APPEND) && !buf_full;
    assign wr_addr   = len_reg[AW-1:0];
    assign rd_addr   = (rp_next < DEPTH_L) ? rp_next[AW-1:0] : '0;
    assign drop      = accept && (cmd.op == OP_APPEND) && buf_full;

    // decode the prefetched character into its element pattern
    always_comb
    begin
        code     = letter_code(5'(rd_data_reg - CHAR_LOWER_A));
        load_pat = '0;
        if (rd_data_reg == CHAR_SPACE)
        begin
            load_len = LEN_SPACE;
        end
        else if (rd_data_reg >= CHAR_LOWER_A && rd_data_reg <= CHAR_LOWER_Z)
        begin
            for (int k = 0; k < CODE_SLOTS; k++)
            begin
                if (3'(k) < code[6:4])
                begin
                    load_pat[2*k +: 2] = code[k] ? 2'd2 : 2'd1;
                end
            end
            load_len = code[6:4] + 3'd1;
        end
        else
        begin
            load_len = LEN_OTHER;
        end
    end

    always_comb
    begin
        len_next  = len_reg;
        rp_next   = rp_reg;
        pat_next  = pat_reg;
        plen_next = plen_reg;
        ep_next   = ep_reg;
        tick_next = tick_reg;
        lamp_next = lamp_reg;
        done_next = done_reg;
        fld       = 2'd0;

        if (accept)
        begin
            unique case (cmd.op) inside
                OP_APPEND:
                begin
                    if (!buf_full)
                    begin
                        len_next = len_reg + LW'(1);
                    end
                end
                OP_TICK:
                begin
                    if (tick_reg >= dot_ticks_reg)
                    begin
                        if (ep_reg >= plen_reg && rp_reg >= len_reg)
                        begin
                            // message exhausted: hold lamp and tick count
                            done_next = 1'b1;
                        end
                        else
                        begin
                            if (ep_reg >= plen_reg)
                            begin
                                pat_next  = load_pat;
                                plen_next = load_len;
                                ep_next   = 3'd0;
                                rp_next   = rp_reg + LW'(1);
                            end
                            for (int k = 0; k < PAT_SLOTS; k++)
                            begin
                                if (ep_next == 3'(k))
                                begin
                                    fld = pat_next[2*k +: 2];
                                end
                            end
                            if (fld != 2'd0)
                            begin
                                for (int k = 0; k < PAT_SLOTS; k++)
                                begin
                                    if (ep_next == 3'(k))
                                    begin
                                        pat_next[2*k +: 2] = fld - 2'd1;
                                    end
                                end
                                lamp_next = 1'b1;
                            end
                            else
                            begin
                                ep_next   = ep_next + 3'd1;
                                lamp_next = 1'b0;
                            end
                            tick_next = 16'd1;
                        end
                    end
                    else
                    begin
                        tick_next = tick_reg + 16'd1;
                    end
                end
                OP_RESTART, OP_CLEAR:
                begin
                    if (cmd.op == OP_CLEAR)
                    begin
                        len_next = '0;
                    end
                    rp_next   = '0;
                    pat_next  = '0;
                    plen_next = 3'd0;
                    ep_next   = 3'd0;
                    tick_next = 16'd0;
                    lamp_next = 1'b0;
                    done_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // keep the character at the next read position ready; bypass a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= folded;
        end
        if (wr_en && wr_addr == rd_addr)
        begin
            rd_data_reg <= folded;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_ticks_reg <= DOT_TICKS_RESET;
            len_reg       <= '0;
            rp_reg        <= '0;
            pat_reg       <= '0;
            plen_reg      <= 3'd0;
            ep_reg        <= 3'd0;
            tick_reg      <= 16'd0;
            lamp_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                dot_ticks_reg <= cfg_wr_data;
            end
            len_reg  <= len_next;
            rp_reg   <= rp_next;
            pat_reg  <= pat_next;
            plen_reg <= plen_next;
            ep_reg   <= ep_next;
            tick_reg <= tick_next;
            lamp_reg <= lamp_next;
            done_reg <= done_next;
        end
    end

    assign res_data.lamp_on  = lamp_next;
    assign res_data.done_res = done_next;
    assign res_data.dropped  = drop;

    mlk_res_fifo u_res_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res_data),
        .full      (fifo_full),
        .res       (res)
    );

endmodule
